// ----- src/fau_pkg.sv -----
// Shared constants, opcodes and sequencer state type for the fraction arithmetic unit.
package fau_pkg;

   // Default operand width, fixed result widths and opcode width
   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int RES_W             = 33;
   localparam int WIDE_W            = 64;
   localparam int OP_W              = 3;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ADD = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV = 3'd3;
   localparam logic [OP_W-1:0] OP_RED = 3'd4;
   localparam logic [OP_W-1:0] OP_CMP = 3'd5;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_GCD,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

// ----- src/fraction_arithmetic_unit.sv -----
// Top level of the fraction arithmetic unit: sequencer, shared multiplier and subtractor.
//
// Usage: a request (opcode plus fractions a = a_num/a_den and b = b_num/b_den) is taken
// on a rising edge with start high and busy low. busy stays high while the request is
// worked on; start is ignored meanwhile. The result (numerator, denominator, greater,
// fault) appears on the rsp_ ports for exactly one cycle, marked by rsp_valid, and the
// receiver cannot hold it off. busy is already low in that cycle.
// Steps from the accepting edge to rsp_valid:
//   add, subtract, multiply, divide, compare: three products through the one signed
//   multiplier, then a finish state that combines them.
//   reduce: binary-GCD steps through the shared subtractor, then two W-step restoring
//   divisions (W = OPERAND_WIDTH) on the same subtractor, then the finish state.
//   zero-numerator or zero-denominator reduce, unused opcodes: the finish state only.
// One request is in flight at a time: a new one is taken only once busy is low again.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
module fraction_arithmetic_unit #(
   parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [fau_pkg::OP_W-1:0]             req_op,
   input  logic signed [OPERAND_WIDTH-1:0]      req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]      req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]      req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]      req_b_den,
   output logic                                 rsp_valid,
   output logic signed [fau_pkg::RES_W-1:0]     rsp_res_num,
   output logic signed [fau_pkg::RES_W-1:0]     rsp_res_den,
   output logic                                 rsp_greater,
   output logic                                 rsp_fault
);

   localparam int W  = OPERAND_WIDTH;
   localparam int KW = $clog2(OPERAND_WIDTH);
   localparam int PW = 2 * OPERAND_WIDTH;

   // State and registers
   fau_pkg::state_type state_ff, state_in;

   logic [fau_pkg::OP_W-1:0]          op_ff, op_in;
   logic signed [W-1:0]               an_ff, an_in, ad_ff, ad_in;
   logic signed [W-1:0]               bn_ff, bn_in, bd_ff, bd_in;
   logic [KW-1:0]                     cnt_ff, cnt_in;
   logic signed [PW-1:0]              prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic [fau_pkg::RES_W-1:0]         den_ff, den_in;
   logic [W-1:0]                      x_ff, x_in, y_ff, y_in;
   logic [KW-1:0]                     k_ff, k_in;
   logic [W-1:0]                      dq_ff, dq_in;
   logic [W-2:0]                      rem_ff, rem_in;
   logic                              pass_ff, pass_in;
   logic [W-1:0]                      qn_ff, qn_in, qd_ff, qd_in;

   logic                              valid_ff, valid_in;
   logic signed [fau_pkg::RES_W-1:0]  res_num_ff, res_num_in, res_den_ff, res_den_in;
   logic                              greater_ff, greater_in, fault_ff, fault_in;

   // Shared multiplier
   logic signed [W-1:0]               mul_x, mul_y;
   logic signed [PW-1:0]              mul_p;
   logic signed [fau_pkg::WIDE_W-1:0] mul_wide, p1_wide, p2_wide;

   // Shared subtractor
   logic [W-1:0]                      sub_a, sub_b;
   logic [W:0]                        sub_d, neg_d;
   logic [W-1:0]                      rem_shift;

   // Helpers
   logic [W-1:0]                      mag_an_req, mag_ad_req, mag_an, mag_ad;
   logic                              req_take, red_special, div_last, gcd_done;
   logic [W-1:0]                      q_next;
   logic [fau_pkg::RES_W-1:0]         qn_ext, qd_ext;

   assign req_take = start && (state_ff == fau_pkg::ST_IDLE);
   assign busy     = (state_ff != fau_pkg::ST_IDLE);

   // Magnitudes of the numerator and denominator of a
   assign mag_an_req = req_a_num[W-1] ? W'(-req_a_num) : W'(req_a_num);
   assign mag_ad_req = req_a_den[W-1] ? W'(-req_a_den) : W'(req_a_den);
   assign mag_an     = an_ff[W-1] ? W'(-an_ff) : W'(an_ff);
   assign mag_ad     = ad_ff[W-1] ? W'(-ad_ff) : W'(ad_ff);

   assign red_special = (an_ff == '0) || (ad_ff == '0);

   // Multiplier operand select: slot 0 and 1 give the numerator terms or the compared products, slot 2 the denominator
   always_comb begin
      mul_x = an_ff;
      mul_y = bd_ff;
      if (cnt_ff == KW'(0)) begin
         mul_x = an_ff;
         mul_y = (op_ff == fau_pkg::OP_MUL) ? bn_ff : bd_ff;
      end else if (cnt_ff == KW'(1)) begin
         mul_x = bn_ff;
         mul_y = ad_ff;
      end else begin
         mul_x = ad_ff;
         mul_y = (op_ff == fau_pkg::OP_DIV) ? bn_ff : bd_ff;
      end
   end

   assign mul_p    = mul_x * mul_y;
   assign mul_wide = fau_pkg::WIDE_W'(mul_p);
   assign p1_wide  = fau_pkg::WIDE_W'(prod1_ff);
   assign p2_wide  = fau_pkg::WIDE_W'(prod2_ff);

   // Subtractor: GCD compares x and y, division trial-subtracts the divisor in x
   assign rem_shift = {rem_ff, dq_ff[W-1]};
   assign sub_a     = (state_ff == fau_pkg::ST_DIV) ? rem_shift : x_ff;
   assign sub_b     = (state_ff == fau_pkg::ST_DIV) ? x_ff : y_ff;
   assign sub_d     = {1'b0, sub_a} - {1'b0, sub_b};
   assign neg_d     = -sub_d;

   assign q_next   = {dq_ff[W-2:0], ~sub_d[W]};
   assign div_last = (cnt_ff == KW'(W - 1));
   assign gcd_done = (x_ff == y_ff);

   assign qn_ext = fau_pkg::RES_W'(qn_ff);
   assign qd_ext = fau_pkg::RES_W'(qd_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fau_pkg::ST_IDLE: begin
            if (start) begin
               if (req_op inside {fau_pkg::OP_ADD, fau_pkg::OP_SUB, fau_pkg::OP_MUL,
                                  fau_pkg::OP_DIV, fau_pkg::OP_CMP}) begin
                  state_in = fau_pkg::ST_MUL;
               end else if ((req_op == fau_pkg::OP_RED) && (req_a_num != '0) &&
                            (req_a_den != '0)) begin
                  state_in = fau_pkg::ST_GCD;
               end else begin
                  state_in = fau_pkg::ST_FIN;
               end
            end
         end
         fau_pkg::ST_MUL: begin
            if (cnt_ff == KW'(2)) state_in = fau_pkg::ST_FIN;
         end
         fau_pkg::ST_GCD: begin
            if (gcd_done) state_in = fau_pkg::ST_DIV;
         end
         fau_pkg::ST_DIV: begin
            if (div_last && pass_ff) state_in = fau_pkg::ST_FIN;
         end
         fau_pkg::ST_FIN: state_in = fau_pkg::ST_IDLE;
         default:         state_in = fau_pkg::ST_IDLE;
      endcase
   end

   // Datapath and result outputs
   always_comb begin
      op_in      = op_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      cnt_in     = cnt_ff;
      prod1_in   = prod1_ff;
      prod2_in   = prod2_ff;
      den_in     = den_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      k_in       = k_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      pass_in    = pass_ff;
      qn_in      = qn_ff;
      qd_in      = qd_ff;
      valid_in   = 1'b0;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      greater_in = greater_ff;
      fault_in   = fault_ff;

      case (state_ff)
         fau_pkg::ST_IDLE: begin
            if (req_take) begin
               op_in  = req_op;
               an_in  = req_a_num;
               ad_in  = req_a_den;
               bn_in  = req_b_num;
               bd_in  = req_b_den;
               cnt_in = '0;
               x_in   = mag_an_req;
               y_in   = mag_ad_req;
               k_in   = '0;
            end
         end

         // three products, one per cycle
         fau_pkg::ST_MUL: begin
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(0)) begin
               prod1_in = mul_p;
            end else if (cnt_ff == KW'(1)) begin
               prod2_in = mul_p;
            end else begin
               den_in = mul_wide[fau_pkg::RES_W-1:0];
            end
         end

         // binary GCD, one step per cycle
         fau_pkg::ST_GCD: begin
            if (gcd_done) begin
               x_in    = x_ff << k_ff;
               dq_in   = mag_an;
               rem_in  = '0;
               cnt_in  = '0;
               pass_in = 1'b0;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!sub_d[W]) begin
               x_in = sub_d[W:1];
            end else begin
               y_in = neg_d[W:1];
            end
         end

         // restoring division by the GCD, numerator first then denominator
         fau_pkg::ST_DIV: begin
            dq_in  = q_next;
            cnt_in = cnt_ff + KW'(1);
            if (!sub_d[W]) rem_in = sub_d[W-2:0];
            else           rem_in = rem_shift[W-2:0];
            if (div_last) begin
               if (!pass_ff) begin
                  qn_in   = q_next;
                  dq_in   = mag_ad;
                  rem_in  = '0;
                  cnt_in  = '0;
                  pass_in = 1'b1;
               end else begin
                  qd_in = q_next;
               end
            end
         end

         // assemble the result
         fau_pkg::ST_FIN: begin
            valid_in   = 1'b1;
            res_num_in = '0;
            res_den_in = fau_pkg::RES_W'(1);
            greater_in = 1'b0;
            fault_in   = 1'b0;
            case (op_ff)
               fau_pkg::OP_ADD: begin
                  res_num_in = p1_wide[fau_pkg::RES_W-1:0] + p2_wide[fau_pkg::RES_W-1:0];
                  res_den_in = den_ff;
                  fault_in   = (ad_ff == '0) || (bd_ff == '0);
               end
               fau_pkg::OP_SUB: begin
                  res_num_in = p1_wide[fau_pkg::RES_W-1:0] - p2_wide[fau_pkg::RES_W-1:0];
                  res_den_in = den_ff;
                  fault_in   = (ad_ff == '0) || (bd_ff == '0);
               end
               fau_pkg::OP_MUL, fau_pkg::OP_DIV: begin
                  res_num_in = p1_wide[fau_pkg::RES_W-1:0];
                  res_den_in = den_ff;
                  fault_in   = (ad_ff == '0) || (bd_ff == '0) ||
                               ((op_ff == fau_pkg::OP_DIV) && (bn_ff == '0));
               end
               fau_pkg::OP_CMP: begin
                  greater_in = (prod1_ff > prod2_ff);
                  fault_in   = (ad_ff == '0) || (bd_ff == '0);
               end
               fau_pkg::OP_RED: begin
                  fault_in = (ad_ff == '0);
                  if (an_ff == '0) begin
                     res_num_in = '0;
                     res_den_in = fau_pkg::RES_W'(1);
                  end else if (red_special) begin
                     res_num_in = fau_pkg::RES_W'(an_ff);
                     res_den_in = '0;
                  end else begin
                     res_num_in = an_ff[W-1] ? -qn_ext : qn_ext;
                     res_den_in = ad_ff[W-1] ? -qd_ext : qd_ext;
                  end
               end
               default: begin
                  res_num_in = '0;
               end
            endcase
         end

         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fau_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      cnt_ff     <= cnt_in;
      prod1_ff   <= prod1_in;
      prod2_ff   <= prod2_in;
      den_ff     <= den_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      pass_ff    <= pass_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      greater_ff <= greater_in;
      fault_ff   <= fault_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_res_num = res_num_ff;
   assign rsp_res_den = res_den_ff;
   assign rsp_greater = greater_ff;
   assign rsp_fault   = fault_ff;

   // Assertions
   a_valid_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == fau_pkg::ST_FIN))
      else $error("result strobe without a finish cycle");

   a_take_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_valid_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fau_pkg::ST_DIV) |-> (x_ff != '0))
      else $error("division by a zero GCD");

endmodule

// ----- tb/fraction_arithmetic_unit_test.sv -----
// Self-checking testbench for the fraction arithmetic unit: directed and random requests.
module fraction_arithmetic_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = fau_pkg::OPERAND_WIDTH_DEF;
   localparam logic [fau_pkg::OP_W-1:0] OP_RSV6 = 3'd6;
   localparam logic [fau_pkg::OP_W-1:0] OP_RSV7 = 3'd7;
   localparam logic signed [W-1:0] MIN_OPERAND = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] MAX_OPERAND = {1'b0, {(W-1){1'b1}}};
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int QUIET_ITEMS   = 150;
   localparam int DRAIN_CYCLES  = 4 * W + 20;
   localparam int LIMIT_CYCLES  = 600000;
   localparam int REPORT_LIMIT  = 10;

   // One request together with the result it must produce
   typedef struct {
      logic [fau_pkg::OP_W-1:0]         op;
      logic signed [W-1:0]              a_num, a_den, b_num, b_den;
      logic signed [fau_pkg::RES_W-1:0] res_num, res_den;
      logic                             greater, fault;
   } fraction_outcome_type;

   // Predicts results of accepted requests and checks the block's results in order
   class fraction_checker;
      fraction_outcome_type awaited[$];
      int mismatches;
      int results_checked;
      int faults_seen;
      int op_seen[8];

      function longint gcd_of_magnitudes(longint x, longint y);
         longint r;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         return x;
      endfunction

      function fraction_outcome_type predict_fraction(logic [fau_pkg::OP_W-1:0] op,
            logic signed [W-1:0] an_in, logic signed [W-1:0] ad_in,
            logic signed [W-1:0] bn_in, logic signed [W-1:0] bd_in);
         fraction_outcome_type r;
         longint an, ad, bn, bd, g;
         bit den_zero;
         an = an_in;
         ad = ad_in;
         bn = bn_in;
         bd = bd_in;
         den_zero = (ad == 0) || (bd == 0);
         r.op = op;
         r.a_num = an_in;
         r.a_den = ad_in;
         r.b_num = bn_in;
         r.b_den = bd_in;
         r.res_num = '0;
         r.res_den = 1;
         r.greater = 1'b0;
         r.fault = 1'b0;
         case (op)
            fau_pkg::OP_ADD: begin
               r.res_num = fau_pkg::RES_W'(an * bd + bn * ad);
               r.res_den = fau_pkg::RES_W'(ad * bd);
               r.fault = den_zero;
            end
            fau_pkg::OP_SUB: begin
               r.res_num = fau_pkg::RES_W'(an * bd - bn * ad);
               r.res_den = fau_pkg::RES_W'(ad * bd);
               r.fault = den_zero;
            end
            fau_pkg::OP_MUL: begin
               r.res_num = fau_pkg::RES_W'(an * bn);
               r.res_den = fau_pkg::RES_W'(ad * bd);
               r.fault = den_zero;
            end
            fau_pkg::OP_DIV: begin
               r.res_num = fau_pkg::RES_W'(an * bd);
               r.res_den = fau_pkg::RES_W'(ad * bn);
               r.fault = den_zero || (bn == 0);
            end
            fau_pkg::OP_RED: begin
               r.fault = (ad == 0);
               // zero numerator always reduces to 0/1; zero denominator stays unreduced
               if (an == 0) begin
                  r.res_num = '0;
                  r.res_den = 1;
               end else if (ad == 0) begin
                  r.res_num = fau_pkg::RES_W'(an);
                  r.res_den = '0;
               end else begin
                  g = gcd_of_magnitudes((an < 0) ? -an : an, (ad < 0) ? -ad : ad);
                  r.res_num = fau_pkg::RES_W'(an / g);
                  r.res_den = fau_pkg::RES_W'(ad / g);
               end
            end
            fau_pkg::OP_CMP: begin
               r.greater = (an * bd > bn * ad);
               r.fault = den_zero;
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(logic [fau_pkg::OP_W-1:0] op, logic signed [W-1:0] an,
            logic signed [W-1:0] ad, logic signed [W-1:0] bn, logic signed [W-1:0] bd);
         awaited.push_back(predict_fraction(op, an, ad, bn, bd));
         op_seen[op]++;
      endfunction

      function void check_result(logic signed [fau_pkg::RES_W-1:0] num,
            logic signed [fau_pkg::RES_W-1:0] den, logic greater, logic fault);
         fraction_outcome_type e;
         results_checked++;
         if (fault === 1'b1)
            faults_seen++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with no request waiting: num %0d den %0d gt %b fault %b",
                        $realtime, num, den, greater, fault);
            return;
         end
         e = awaited.pop_front();
         if (num !== e.res_num || den !== e.res_den || greater !== e.greater ||
               fault !== e.fault) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: mismatch op %0d a %0d/%0d b %0d/%0d", $realtime, e.op,
                        e.a_num, e.a_den, e.b_num, e.b_den);
               $display("   expected num %0d den %0d gt %b fault %b",
                        e.res_num, e.res_den, e.greater, e.fault);
               $display("   got      num %0d den %0d gt %b fault %b",
                        num, den, greater, fault);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [fau_pkg::OP_W-1:0]         req_op = '0;
   logic signed [W-1:0]              req_a_num = '0;
   logic signed [W-1:0]              req_a_den = '0;
   logic signed [W-1:0]              req_b_num = '0;
   logic signed [W-1:0]              req_b_den = '0;
   logic                             rsp_valid;
   logic signed [fau_pkg::RES_W-1:0] rsp_res_num;
   logic signed [fau_pkg::RES_W-1:0] rsp_res_den;
   logic                             rsp_greater;
   logic                             rsp_fault;
   int                               cycle_count = 0;

   fraction_checker book = new;

   fraction_arithmetic_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .rsp_valid   (rsp_valid),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_greater (rsp_greater),
      .rsp_fault   (rsp_fault)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor: check results first, then record the request accepted at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            book.check_result(rsp_res_num, rsp_res_den, rsp_greater, rsp_fault);
         if (start && !busy)
            book.note_request(req_op, req_a_num, req_a_den, req_b_num, req_b_den);
      end
   end

   // Run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               book.pending());
      $display("fraction_arithmetic_unit test failed");
      $finish;
   end

   // Operand mix: zero, extremes, small values and full-range values
   function automatic logic signed [W-1:0] pick_operand();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: return '0;
         1: begin
            case (raw[1:0])
               2'd0:    return MIN_OPERAND;
               2'd1:    return MAX_OPERAND;
               2'd2:    return W'(1);
               default: return W'(-1);
            endcase
         end
         2, 3: return W'($signed($urandom_range(0, 40)) - 20);
         default: return raw[W-1:0];
      endcase
   endfunction

   // Present one request, hold it until accepted, then maybe idle for a short burst
   task automatic send_request(input logic [fau_pkg::OP_W-1:0] op,
         input logic signed [W-1:0] an, input logic signed [W-1:0] ad,
         input logic signed [W-1:0] bn, input logic signed [W-1:0] bd,
         input bit allow_idle);
      start     <= 1'b1;
      req_op    <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      do
         @(posedge clock);
      while (busy);
      if (allow_idle && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         // half the gaps start once the block has gone idle again
         if ($urandom_range(0, 1)) begin
            do
               @(posedge clock);
            while (busy);
            repeat ($urandom_range(0, 2))
               @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 3))
               @(posedge clock);
         end
      end
   endtask

   task automatic send_random_request(input bit allow_idle);
      logic [fau_pkg::OP_W-1:0] op;
      logic signed [W-1:0]      an, ad, bn, bd;
      int                       factor;
      if ($urandom_range(0, 19) == 0)
         op = fau_pkg::OP_W'($urandom_range(OP_RSV6, OP_RSV7));
      else
         op = fau_pkg::OP_W'($urandom_range(fau_pkg::OP_ADD, fau_pkg::OP_CMP));
      an = pick_operand();
      ad = pick_operand();
      bn = pick_operand();
      bd = pick_operand();
      // reduce: often give both parts a large common factor
      if (op == fau_pkg::OP_RED && $urandom_range(0, 2) != 0) begin
         factor = $urandom_range(1, 255);
         an = W'(factor * $urandom_range(1, 127));
         ad = W'(factor * $urandom_range(1, 127));
         if ($urandom_range(0, 1))
            an = -an;
         if ($urandom_range(0, 1))
            ad = -ad;
      end
      // compare: equal fractions hit the boundary
      if (op == fau_pkg::OP_CMP && $urandom_range(0, 3) == 0) begin
         bn = an;
         bd = ad;
      end
      send_request(op, an, ad, bn, bd, allow_idle);
   endtask

   initial begin
      repeat (RESET_CYCLES)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero denominators and divisors, reduce corner cases
      send_request(fau_pkg::OP_ADD, MAX_OPERAND, MAX_OPERAND, MAX_OPERAND, MAX_OPERAND, 1);
      send_request(fau_pkg::OP_ADD, MIN_OPERAND, MIN_OPERAND, MIN_OPERAND, MIN_OPERAND, 1);
      send_request(fau_pkg::OP_ADD, 1, 0, 1, 3, 1);
      send_request(fau_pkg::OP_SUB, MIN_OPERAND, MAX_OPERAND, MAX_OPERAND, MIN_OPERAND, 1);
      send_request(fau_pkg::OP_SUB, 5, 7, -3, 0, 1);
      send_request(fau_pkg::OP_MUL, MIN_OPERAND, MIN_OPERAND, MIN_OPERAND, MIN_OPERAND, 1);
      send_request(fau_pkg::OP_MUL, MAX_OPERAND, -1, MIN_OPERAND, 1, 1);
      send_request(fau_pkg::OP_DIV, 3, 4, 0, 5, 1);
      send_request(fau_pkg::OP_DIV, MIN_OPERAND, MAX_OPERAND, -1, MIN_OPERAND, 1);
      send_request(fau_pkg::OP_DIV, 7, 0, 2, 3, 1);
      send_request(fau_pkg::OP_RED, 12, -18, 0, 0, 1);
      send_request(fau_pkg::OP_RED, 0, 5, 1, 1, 1);
      send_request(fau_pkg::OP_RED, 7, 0, 1, 1, 1);
      send_request(fau_pkg::OP_RED, 0, 0, 0, 0, 1);
      send_request(fau_pkg::OP_RED, MIN_OPERAND, MIN_OPERAND, MAX_OPERAND, MAX_OPERAND, 1);
      send_request(fau_pkg::OP_RED, MIN_OPERAND, 1, 0, 0, 1);
      send_request(fau_pkg::OP_RED, MAX_OPERAND, MIN_OPERAND, 0, 0, 1);
      send_request(fau_pkg::OP_RED, -30030, 4410, 0, 0, 1);
      send_request(fau_pkg::OP_CMP, 1, 2, 1, 3, 1);
      send_request(fau_pkg::OP_CMP, 1, 3, 1, 2, 1);
      send_request(fau_pkg::OP_CMP, 2, 4, 1, 2, 1);
      send_request(fau_pkg::OP_CMP, 1, 0, 1, 1, 1);
      send_request(fau_pkg::OP_CMP, 1, -2, 1, 3, 1);
      send_request(OP_RSV6, MAX_OPERAND, 0, MAX_OPERAND, 0, 1);
      send_request(OP_RSV7, MIN_OPERAND, MIN_OPERAND, 0, 0, 1);

      // Random traffic with idle bursts, then a stretch back to back
      repeat (RANDOM_ITEMS)
         send_random_request(1);
      repeat (QUIET_ITEMS)
         send_random_request(0);
      start <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (book.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      $display("requests: add %0d, sub %0d, mul %0d, div %0d, reduce %0d, compare %0d",
               book.op_seen[fau_pkg::OP_ADD], book.op_seen[fau_pkg::OP_SUB],
               book.op_seen[fau_pkg::OP_MUL], book.op_seen[fau_pkg::OP_DIV],
               book.op_seen[fau_pkg::OP_RED], book.op_seen[fau_pkg::OP_CMP]);
      $display("unused %0d; %0d results checked (%0d flagged fault), %0d mismatches, %0d cycles",
               book.op_seen[OP_RSV6] + book.op_seen[OP_RSV7], book.results_checked,
               book.faults_seen, book.mismatches, cycle_count);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("fraction_arithmetic_unit test passed");
      else
         $display("fraction_arithmetic_unit test failed");
      $finish;
   end

endmodule
